// File: sv/i2cbc_pkg.sv
package i2cbc_pkg;

  localparam int TIMER_BITS_DEF = 20;

  // register field widths
  localparam int SETTLE_W = 20;
  localparam int HALF_W   = 10;
  localparam int POLL_W   = 20;
  localparam int COUNT_W  = 8;
  localparam int LONG_W   = 20;  // widest tick count held in a register

  localparam int APB_DW = 32;
  localparam int APB_AW = 5;

  // register indexes, paddr[4:2]
  localparam logic [2:0] REG_SETTLE     = 3'd0;
  localparam logic [2:0] REG_HALF       = 3'd1;
  localparam logic [2:0] REG_POLL       = 3'd2;
  localparam logic [2:0] REG_MAX_POLLS  = 3'd3;
  localparam logic [2:0] REG_MAX_PULSES = 3'd4;

  // register reset values
  localparam logic [SETTLE_W-1:0] SETTLE_RST     = SETTLE_W'(100000);
  localparam logic [HALF_W-1:0]   HALF_RST       = HALF_W'(20);
  localparam logic [POLL_W-1:0]   POLL_RST       = POLL_W'(100000);
  localparam logic [COUNT_W-1:0]  MAX_POLLS_RST  = COUNT_W'(20);
  localparam logic [COUNT_W-1:0]  MAX_PULSES_RST = COUNT_W'(40);

  // outcome codes
  localparam logic [2:0] OC_OK       = 3'd0;
  localparam logic [2:0] OC_REPAIRED = 3'd1;
  localparam logic [2:0] OC_CLK_LOW  = 3'd2;
  localparam logic [2:0] OC_STRETCH  = 3'd3;
  localparam logic [2:0] OC_SDA_LOW  = 3'd4;

  localparam int IN_DW  = 8;
  localparam int OUT_DW = 16;

  typedef struct packed {
    logic [SETTLE_W-1:0] settle_ticks;
    logic [HALF_W-1:0]   half_period_ticks;
    logic [POLL_W-1:0]   poll_interval_ticks;
    logic [COUNT_W-1:0]  max_stretch_polls;
    logic [COUNT_W-1:0]  max_clock_pulses;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] pulse_total;
    logic [2:0]         outcome;
    logic               finished;
    logic               busy_res;
    logic               sda_pull_low;
    logic               scl_pull_low;
  } result_t;

endpackage

// File: sv/i2cbc_regs.sv
module i2cbc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [i2cbc_pkg::APB_AW-1:0] paddr,
  input  logic [i2cbc_pkg::APB_DW-1:0] pwdata,
  output logic [i2cbc_pkg::APB_DW-1:0] prdata,
  output i2cbc_pkg::cfg_t              cfg
);
  import i2cbc_pkg::*;

  logic [2:0] idx;
  logic       wr_en;

  assign idx   = paddr[4:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks        <= SETTLE_RST;
      cfg.half_period_ticks   <= HALF_RST;
      cfg.poll_interval_ticks <= POLL_RST;
      cfg.max_stretch_polls   <= MAX_POLLS_RST;
      cfg.max_clock_pulses    <= MAX_PULSES_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SETTLE:     cfg.settle_ticks        <= pwdata[SETTLE_W-1:0];
        REG_HALF:       cfg.half_period_ticks   <= pwdata[HALF_W-1:0];
        REG_POLL:       cfg.poll_interval_ticks <= pwdata[POLL_W-1:0];
        REG_MAX_POLLS:  cfg.max_stretch_polls   <= pwdata[COUNT_W-1:0];
        REG_MAX_PULSES: cfg.max_clock_pulses    <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SETTLE:     prdata = APB_DW'(cfg.settle_ticks);
      REG_HALF:       prdata = APB_DW'(cfg.half_period_ticks);
      REG_POLL:       prdata = APB_DW'(cfg.poll_interval_ticks);
      REG_MAX_POLLS:  prdata = APB_DW'(cfg.max_stretch_polls);
      REG_MAX_PULSES: prdata = APB_DW'(cfg.max_clock_pulses);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: sv/i2cbc_seq.sv
module i2cbc_seq #(
  parameter int TIMER_BITS = i2cbc_pkg::TIMER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  i2cbc_pkg::cfg_t      cfg,
  input  logic                 step,
  input  logic                 action,
  input  logic                 scl_level,
  input  logic                 sda_level,
  output i2cbc_pkg::result_t   res_next
);
  import i2cbc_pkg::*;

  localparam int LW = (TIMER_BITS > LONG_W) ? TIMER_BITS : LONG_W;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SETTLE, PH_LOW, PH_HIGH, PH_STRETCH, PH_START, PH_STOP
  } phase_t;

  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] wait_timer, wait_timer_next;
  logic [COUNT_W-1:0]    pulses_left, pulses_left_next;
  logic [COUNT_W-1:0]    polls_left, polls_left_next;
  logic [COUNT_W-1:0]    repair_tally, repair_tally_next;
  logic [2:0]            last_outcome, last_outcome_next;
  logic                  done_next;

  // wait of n ticks: load n-1, zero acts as one, saturate to timer width
  function automatic logic [TIMER_BITS-1:0] load_ticks(input logic [LONG_W-1:0] n);
    logic [LONG_W-1:0] nm1;
    logic [LW-1:0]     ext;
    nm1 = (n == '0) ? '0 : n - 1'b1;
    ext = LW'(nm1);
    if ((ext >> TIMER_BITS) != '0) return '1;
    else return ext[TIMER_BITS-1:0];
  endfunction

  logic [TIMER_BITS-1:0] half_load, poll_load, settle_load;
  assign half_load   = load_ticks(LONG_W'(cfg.half_period_ticks));
  assign poll_load   = load_ticks(cfg.poll_interval_ticks);
  assign settle_load = load_ticks(cfg.settle_ticks);

  always_comb begin
    phase_next        = phase;
    wait_timer_next   = wait_timer;
    pulses_left_next  = pulses_left;
    polls_left_next   = polls_left;
    repair_tally_next = repair_tally;
    last_outcome_next = last_outcome;
    done_next         = 1'b0;

    if (phase != PH_IDLE && wait_timer != '0) begin
      wait_timer_next = wait_timer - 1'b1;
    end else begin
      unique case (phase) inside
        PH_IDLE: begin
          if (action) begin
            phase_next      = PH_SETTLE;
            wait_timer_next = settle_load;
          end
        end
        PH_SETTLE: begin
          if (!scl_level) begin
            phase_next = PH_IDLE; wait_timer_next = '0;
            last_outcome_next = OC_CLK_LOW; done_next = 1'b1;
          end else if (sda_level) begin
            phase_next = PH_IDLE; wait_timer_next = '0;
            last_outcome_next = OC_OK; done_next = 1'b1;
          end else if (cfg.max_clock_pulses == '0) begin
            pulses_left_next = '0;
            phase_next = PH_IDLE; wait_timer_next = '0;
            last_outcome_next = OC_SDA_LOW; done_next = 1'b1;
          end else begin
            pulses_left_next = cfg.max_clock_pulses - 1'b1;
            phase_next       = PH_LOW;
            wait_timer_next  = half_load;
          end
        end
        PH_LOW: begin
          phase_next      = PH_HIGH;
          wait_timer_next = half_load;
        end
        PH_HIGH, PH_STRETCH: begin
          if (phase == PH_HIGH) begin
            repair_tally_next = repair_tally + 1'b1;
            polls_left_next   = cfg.max_stretch_polls;
          end else begin
            polls_left_next = polls_left - 1'b1;
          end
          if (scl_level) begin
            // clock is up: data free sends start/stop, else next pulse or SDA-low end
            if (sda_level) begin
              phase_next      = PH_START;
              wait_timer_next = half_load;
            end else if (pulses_left == '0) begin
              phase_next = PH_IDLE; wait_timer_next = '0;
              last_outcome_next = OC_SDA_LOW; done_next = 1'b1;
            end else begin
              pulses_left_next = pulses_left - 1'b1;
              phase_next       = PH_LOW;
              wait_timer_next  = half_load;
            end
          end else if (polls_left_next == '0) begin
            phase_next = PH_IDLE; wait_timer_next = '0;
            last_outcome_next = OC_STRETCH; done_next = 1'b1;
          end else begin
            phase_next      = PH_STRETCH;
            wait_timer_next = poll_load;
          end
        end
        PH_START: begin
          phase_next      = PH_STOP;
          wait_timer_next = half_load;
        end
        PH_STOP: begin
          phase_next = PH_IDLE; wait_timer_next = '0;
          last_outcome_next = OC_REPAIRED; done_next = 1'b1;
        end
        default: begin
          phase_next      = PH_IDLE;
          wait_timer_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      wait_timer   <= '0;
      pulses_left  <= '0;
      polls_left   <= '0;
      repair_tally <= '0;
      last_outcome <= OC_OK;
    end else if (step) begin
      phase        <= phase_next;
      wait_timer   <= wait_timer_next;
      pulses_left  <= pulses_left_next;
      polls_left   <= polls_left_next;
      repair_tally <= repair_tally_next;
      last_outcome <= last_outcome_next;
    end
  end

  always_comb begin
    res_next.scl_pull_low = (phase_next == PH_LOW);
    res_next.sda_pull_low = (phase_next == PH_START);
    res_next.busy_res     = (phase_next != PH_IDLE);
    res_next.finished     = done_next;
    res_next.outcome      = last_outcome_next;
    res_next.pulse_total  = repair_tally_next;
  end

endmodule

// File: sv/i2c_bus_clear_recovery_top.sv
// I2C bus clear / recovery sequencer for one open-drain bus.
//
// Input stream (s_*): one beat per time tick, carrying the start request
// and the sampled SCL/SDA levels. Output stream (m_*): exactly one beat
// per input beat, showing pin pulls and status after that tick.
// The result is registered as the input beat is taken, valid the next cycle.
// Throughput: one beat per cycle while the receiver keeps up; the sequencer state
// and the result register update in the same cycle the beat is accepted.
// s_tready is high whenever the result register is empty or is being
// drained this cycle, so a stalled receiver holds one finished beat and
// backs up the input side; nothing is dropped or repeated.
// Configuration: APB registers at byte offsets 0x00 settle, 0x04 half
// period, 0x08 poll interval, 0x0C max stretch polls, 0x10 max pulses.
// Write only while the sequencer is idle.
// Reset (rst, synchronous): registers return to defaults, sequencer idle,
// repair tally and last outcome cleared, output empty.
module i2c_bus_clear_recovery_top #(
  parameter int TIMER_BITS = i2cbc_pkg::TIMER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cbc_pkg::APB_AW-1:0]  paddr,
  input  logic [i2cbc_pkg::APB_DW-1:0]  pwdata,
  output logic [i2cbc_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  // tick stream in
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [i2cbc_pkg::IN_DW-1:0]   s_tdata,  // [0] action, [1] scl_level,
                                                  // [2] sda_level, rest zero
  // status stream out
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [i2cbc_pkg::OUT_DW-1:0]  m_tdata   // [0] scl_pull_low,
                                                  // [1] sda_pull_low, [2] busy_res,
                                                  // [3] finished, [6:4] outcome,
                                                  // [14:7] pulse_total, [15] zero
);
  import i2cbc_pkg::*;

  cfg_t    cfg;
  result_t res_next;
  logic    step;

  assign pready   = 1'b1;
  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  i2cbc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  i2cbc_seq #(.TIMER_BITS(TIMER_BITS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .action    (s_tdata[0]),
    .scl_level (s_tdata[1]),
    .sda_level (s_tdata[2]),
    .res_next  (res_next)
  );

  // output register: valid is control, data is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= OUT_DW'(res_next);
    end
  end

endmodule

// File: sv/i2cbc_checker.sv
module i2cbc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [i2cbc_pkg::OUT_DW-1:0]  m_tdata
);
  import i2cbc_pkg::*;

  // every accepted tick yields a result beat next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("no result beat after accepted tick");

  // a stalled result beat keeps its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  // sequence end reports idle
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> !m_tdata[2])
    else $error("finished while still busy");

  // pins are only pulled while a sequence runs, never both together
  a_pull_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[0] || m_tdata[1]) |-> m_tdata[2] && !(m_tdata[0] && m_tdata[1]))
    else $error("pin pulled outside sequence");

  a_outcome_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[6:4] <= OC_SDA_LOW)
    else $error("outcome code out of range");

endmodule

bind i2c_bus_clear_recovery_top i2cbc_checker u_i2cbc_checker (.*);

// File: dv/i2c_bus_clear_recovery_top_tb.sv
`timescale 1ns / 100ps

module i2c_bus_clear_recovery_top_tb;
  import i2cbc_pkg::*;

  localparam int TICK_BITS    = TIMER_BITS_DEF;
  localparam int RANDOM_TICKS = 1400;

  // sequencer phases as the shadow model tracks them
  typedef enum logic [3:0] {
    SQ_IDLE, SQ_SETTLE, SQ_LOW, SQ_HIGH, SQ_STRETCH, SQ_START, SQ_STOP
  } seq_phase_t;

  // how the emulated bus answers during one recovery run
  typedef enum int {BUS_NORMAL, BUS_OK, BUS_CLK_STUCK, BUS_NOISE} bus_kind_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_DW-1:0]    s_tdata;   // [0] action, [1] scl_level, [2] sda_level
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_DW-1:0]   m_tdata;   // [0] scl_pull_low, [1] sda_pull_low, [2] busy_res,
                                  // [3] finished, [6:4] outcome, [14:7] pulse_total

  i2c_bus_clear_recovery_top dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the sequencer: registers plus state, advanced once per
  // accepted tick beat.
  // ---------------------------------------------------------------------------
  cfg_t        cfg_shadow;
  seq_phase_t  ph;
  int unsigned wait_cnt;
  logic [7:0]  pulses_left;
  logic [7:0]  polls_left;
  logic [7:0]  tally;
  logic [2:0]  last_oc;
  logic        ended;
  int          seq_pulses;      // pulses sent in the current run

  result_t     status_q[$];     // expected status beats, oldest first

  int fail_cnt;
  int tick_cnt;
  int beat_cnt;
  int cfg_writes;
  int cycle_cnt;
  int outcome_cnt[8];

  // timer load for an n-tick wait, saturated to the timer width
  function automatic int unsigned count_load(input int unsigned n);
    longint unsigned v;
    longint unsigned tmax;
    tmax = (64'd1 << TICK_BITS) - 1;
    v = (n == 0) ? 0 : n - 1;
    if (v > tmax) v = tmax;
    return v[31:0];
  endfunction

  function automatic void end_seq(input logic [2:0] code);
    ph       = SQ_IDLE;
    wait_cnt = 0;
    last_oc  = code;
    ended    = 1'b1;
  endfunction

  // SCL seen high: either go to start/stop, give up, or send another pulse
  function automatic void pulse_or_end(input logic sda);
    if (sda) begin
      ph       = SQ_START;
      wait_cnt = count_load(cfg_shadow.half_period_ticks);
    end else if (pulses_left == 0) begin
      end_seq(OC_SDA_LOW);
    end else begin
      pulses_left = pulses_left - 8'd1;
      ph          = SQ_LOW;
      wait_cnt    = count_load(cfg_shadow.half_period_ticks);
    end
  endfunction

  function automatic result_t tick_recovery(input logic act, input logic scl,
                                            input logic sda);
    result_t r;
    ended = 1'b0;
    if (ph != SQ_IDLE && wait_cnt != 0) begin
      wait_cnt--;
    end else begin
      case (ph)
        SQ_IDLE: begin
          if (act) begin
            ph         = SQ_SETTLE;
            wait_cnt   = count_load(cfg_shadow.settle_ticks);
            seq_pulses = 0;
          end
        end
        SQ_SETTLE: begin
          if (!scl) begin
            end_seq(OC_CLK_LOW);
          end else if (sda) begin
            end_seq(OC_OK);
          end else begin
            pulses_left = cfg_shadow.max_clock_pulses;
            pulse_or_end(1'b0);
          end
        end
        SQ_LOW: begin
          ph       = SQ_HIGH;
          wait_cnt = count_load(cfg_shadow.half_period_ticks);
        end
        SQ_HIGH: begin
          tally = tally + 8'd1;
          seq_pulses++;
          if (scl) begin
            pulse_or_end(sda);
          end else begin
            polls_left = cfg_shadow.max_stretch_polls;
            if (polls_left == 0) begin
              end_seq(OC_STRETCH);
            end else begin
              ph       = SQ_STRETCH;
              wait_cnt = count_load(cfg_shadow.poll_interval_ticks);
            end
          end
        end
        SQ_STRETCH: begin
          polls_left = polls_left - 8'd1;
          if (scl) begin
            pulse_or_end(sda);
          end else if (polls_left == 0) begin
            end_seq(OC_STRETCH);
          end else begin
            wait_cnt = count_load(cfg_shadow.poll_interval_ticks);
          end
        end
        SQ_START: begin
          ph       = SQ_STOP;
          wait_cnt = count_load(cfg_shadow.half_period_ticks);
        end
        SQ_STOP: begin
          end_seq(OC_REPAIRED);
        end
        default: begin
          ph       = SQ_IDLE;
          wait_cnt = 0;
        end
      endcase
    end
    r.scl_pull_low = (ph == SQ_LOW);
    r.sda_pull_low = (ph == SQ_START);
    r.busy_res     = (ph != SQ_IDLE);
    r.finished     = ended;
    r.outcome      = last_oc;
    r.pulse_total  = tally;
    return r;
  endfunction

  function automatic cfg_t make_cfg(input int settle, input int half, input int poll,
                                    input int polls, input int pulses);
    cfg_t c;
    c.settle_ticks        = SETTLE_W'(settle);
    c.half_period_ticks   = HALF_W'(half);
    c.poll_interval_ticks = POLL_W'(poll);
    c.max_stretch_polls   = COUNT_W'(polls);
    c.max_clock_pulses    = COUNT_W'(pulses);
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("MISMATCH: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("i2c_bus_clear_recovery_top verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver pacing: mostly ready, short and occasional long stalls, and
  // one counter window in every four in which no new stall is started.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_cnt;
    int r;
    hold_cnt = 0;
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (hold_cnt > 0) begin
        hold_cnt--;
      end else if ((cycle_cnt / 512) % 4 == 1) begin
        m_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_tready <= 1'b1;
          hold_cnt = $urandom_range(0, 5);
        end else if (r < 95) begin
          m_tready <= 1'b0;
          hold_cnt = $urandom_range(0, 2);
        end else begin
          m_tready <= 1'b0;
          hold_cnt = $urandom_range(10, 30);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Status checker: every output beat against the oldest expectation.
  // Values are read before this edge's updates land, so no race.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      got = result_t'(m_tdata[14:0]);
      if (status_q.size() == 0) begin
        report_mismatch($sformatf("status beat %0d with nothing expected: %h",
                                  beat_cnt, m_tdata));
      end else begin
        want = status_q.pop_front();
        if (want.finished) outcome_cnt[want.outcome]++;
        if (got !== want || m_tdata[15] !== 1'b0) begin
          report_mismatch({
            $sformatf("beat %0d exp scl=%0b sda=%0b busy=%0b fin=%0b oc=%0d tot=%0d",
                      beat_cnt, want.scl_pull_low, want.sda_pull_low, want.busy_res,
                      want.finished, want.outcome, want.pulse_total),
            $sformatf(" got %0b %0b %0b %0b %0d %0d pad=%0b", got.scl_pull_low,
                      got.sda_pull_low, got.busy_res, got.finished, got.outcome,
                      got.pulse_total, m_tdata[15])});
        end
      end
      beat_cnt++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tick beat driver, shared by every test. Random gap in front of the beat,
  // none during every fourth run of 200 beats.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input logic act, input logic scl, input logic sda);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if ((tick_cnt / 200) % 4 == 2) gap = 0;
    else if (r < 75) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DW'({sda, scl, act});
    do @(posedge clk); while (s_tready !== 1'b1);
    status_q.push_back(tick_recovery(act, scl, sda));
    tick_cnt++;
  endtask

  // finish any running sequence on a healthy bus, then let the output drain
  task automatic drain_to_idle();
    while (ph != SQ_IDLE) send_tick(1'b0, ph != SQ_LOW, ph != SQ_START);
    s_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  // APB write: setup then access; upper bits beyond the field carry junk
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value,
                           input int width);
    logic [31:0] w;
    logic [31:0] mask;
    mask = 32'((64'd1 << width) - 1);
    w = ($urandom() & ~mask) | (value & mask);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= w;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_writes++;
  endtask

  task automatic check_reg(input logic [2:0] idx, input logic [31:0] value,
                           input int width);
    logic [31:0] got;
    logic [31:0] mask;
    mask = 32'((64'd1 << width) - 1);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) !== (value & mask))
      report_mismatch($sformatf("register %0d read %h, expected %h", idx,
                                got & mask, value & mask));
  endtask

  task automatic check_all_regs();
    check_reg(REG_SETTLE,     32'(cfg_shadow.settle_ticks),        SETTLE_W);
    check_reg(REG_HALF,       32'(cfg_shadow.half_period_ticks),   HALF_W);
    check_reg(REG_POLL,       32'(cfg_shadow.poll_interval_ticks), POLL_W);
    check_reg(REG_MAX_POLLS,  32'(cfg_shadow.max_stretch_polls),   COUNT_W);
    check_reg(REG_MAX_PULSES, 32'(cfg_shadow.max_clock_pulses),    COUNT_W);
  endtask

  // only with the sequencer idle and every status beat collected
  task automatic apply_config(input cfg_t c);
    drain_to_idle();
    write_reg(REG_SETTLE,     32'(c.settle_ticks),        SETTLE_W);
    write_reg(REG_HALF,       32'(c.half_period_ticks),   HALF_W);
    write_reg(REG_POLL,       32'(c.poll_interval_ticks), POLL_W);
    write_reg(REG_MAX_POLLS,  32'(c.max_stretch_polls),   COUNT_W);
    write_reg(REG_MAX_PULSES, 32'(c.max_clock_pulses),    COUNT_W);
    cfg_shadow = c;
    check_all_regs();
  endtask

  // ---------------------------------------------------------------------------
  // One recovery run against an emulated bus. In the normal case the slave
  // holds SDA until sda_hold pulses have gone by and now and then stretches
  // the high half of a pulse.
  // ---------------------------------------------------------------------------
  task automatic run_sequence(input bus_kind_t kind, input int sda_hold);
    int   n_idle;
    int   stretch_left;
    int   span;
    logic act;
    logic scl;
    logic sda;
    n_idle = $urandom_range(0, 2);
    repeat (n_idle) send_tick(1'b0, 1'($urandom), 1'($urandom));
    span = int'(cfg_shadow.max_stretch_polls) *
           ((cfg_shadow.poll_interval_ticks == 0) ? 1 : int'(cfg_shadow.poll_interval_ticks))
           + 3;
    stretch_left = 0;
    send_tick(1'b1, 1'($urandom), 1'($urandom));
    while (ph != SQ_IDLE) begin
      act = ($urandom_range(0, 9) == 0);   // start while busy is ignored
      case (kind)
        BUS_NOISE: begin
          scl = 1'($urandom);
          sda = 1'($urandom);
        end
        BUS_CLK_STUCK: begin
          scl = 1'b0;
          sda = 1'($urandom);
        end
        default: begin
          if (ph == SQ_LOW)
            stretch_left = ($urandom_range(0, 9) < 7) ? 0 :
                           $urandom_range(1, span) + int'(cfg_shadow.half_period_ticks);
          scl = (ph != SQ_LOW);
          if ((ph == SQ_HIGH || ph == SQ_STRETCH) && stretch_left > 0) begin
            scl = 1'b0;
            stretch_left--;
          end
          sda = (ph != SQ_START) && (seq_pulses >= sda_hold);
        end
      endcase
      send_tick(act, scl, sda);
    end
  endtask

  task automatic random_sequence();
    int r;
    int pulses;
    int hold;
    r = $urandom_range(0, 99);
    pulses = int'(cfg_shadow.max_clock_pulses);
    if (r < 10) begin
      run_sequence(BUS_CLK_STUCK, 0);
    end else if (r < 25) begin
      run_sequence(BUS_OK, 0);
    end else if (r < 85) begin
      // a quarter of the runs never get SDA back
      hold = ($urandom_range(0, 3) == 0) ? pulses + 1 :
             $urandom_range(1, ((pulses < 8) ? pulses : 8) + 1);
      run_sequence(BUS_NORMAL, hold);
    end else begin
      run_sequence(BUS_NOISE, 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // outputs quiet after reset, registers read back their defaults
  task automatic test_reset_state();
    repeat (5) send_tick(1'b0, 1'($urandom), 1'($urandom));
    drain_to_idle();
    check_all_regs();
  endtask

  // every outcome once with the shortest timing, zero-length settings included
  task automatic test_directed_outcomes();
    apply_config(make_cfg(0, 0, 0, 0, 0));
    send_tick(1'b1, 1'b0, 1'b0);  // clock held low at the sample
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);  // bus fine
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);  // data low with no pulses allowed
    send_tick(1'b0, 1'b1, 1'b0);

    apply_config(make_cfg(1, 1, 1, 0, 1));
    send_tick(1'b1, 1'b1, 1'b0);  // stretch with no polls allowed
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);  // start request mid-run
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);  // data still low after the last pulse
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);  // one pulse frees the bus
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1);
  endtask

  // widest register values: one full run at a long half period, then
  // the widest settings written and read back while idle
  task automatic test_extreme_registers();
    apply_config(make_cfg(0, 64, 1, 1, 1));
    run_sequence(BUS_NORMAL, 1);
    apply_config(make_cfg(1048575, 1023, 1048575, 255, 255));
    repeat (4) send_tick(1'b0, 1'($urandom), 1'($urandom));
  endtask

  // random runs over a series of small settings, with the largest pulse
  // and poll counts mixed in
  task automatic test_random_recovery();
    int   start_ticks;
    int   setting;
    int   nseq;
    int   i;
    cfg_t c;
    start_ticks = tick_cnt;
    setting = 0;
    while (tick_cnt - start_ticks < RANDOM_TICKS) begin
      c = make_cfg($urandom_range(0, 6), $urandom_range(0, 3), $urandom_range(0, 4),
                   $urandom_range(0, 6), $urandom_range(0, 8));
      case (setting % 6)
        4: begin
          c.max_clock_pulses  = 8'd255;
          c.half_period_ticks = HALF_W'($urandom_range(0, 1));
        end
        5: begin
          c.max_stretch_polls   = 8'd255;
          c.poll_interval_ticks = POLL_W'($urandom_range(0, 1));
        end
        default: ;
      endcase
      apply_config(c);
      nseq = $urandom_range(6, 12);
      for (i = 0; i < nseq && tick_cnt - start_ticks < RANDOM_TICKS; i++)
        random_sequence();
      setting++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main flow
  // ---------------------------------------------------------------------------
  initial begin
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;

    cfg_shadow  = make_cfg(int'(SETTLE_RST), int'(HALF_RST), int'(POLL_RST),
                           int'(MAX_POLLS_RST), int'(MAX_PULSES_RST));
    ph          = SQ_IDLE;
    wait_cnt    = 0;
    pulses_left = '0;
    polls_left  = '0;
    tally       = '0;
    last_oc     = '0;
    ended       = 1'b0;
    seq_pulses  = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_directed_outcomes();
    test_extreme_registers();
    test_random_recovery();

    drain_to_idle();
    repeat (4) @(posedge clk);

    $display("Ran %0d ticks and %0d register writes; runs ended ok %0d, repaired %0d,",
             tick_cnt, cfg_writes, outcome_cnt[OC_OK], outcome_cnt[OC_REPAIRED]);
    $display("clock low %0d, stretch timeout %0d, data stuck %0d; %0d mismatches",
             outcome_cnt[OC_CLK_LOW], outcome_cnt[OC_STRETCH], outcome_cnt[OC_SDA_LOW],
             fail_cnt);
    if (fail_cnt == 0) begin
      $display("i2c_bus_clear_recovery_top verification clean");
    end else begin
      $display("i2c_bus_clear_recovery_top verification failed");
    end
    $finish;
  end

endmodule
